FILE: hdl/wtss_pkg.sv
package wtss_pkg;

   localparam int NUM_W  = 26;
   localparam int REM_W  = 16;
   localparam int COL_W  = 10;
   localparam int CH_N   = 3;
   localparam int CH_W   = 8;
   localparam int TYPE_WRITE = 0;

   typedef struct packed {
      logic                 is_shade;
      logic                 drop;
      logic                 neg;
      logic [13:0]          texel_addr;
      logic [23:0]          texel_value;
      logic [1:0]           tex;
      logic [COL_W-1:0]     col;
      logic [15:0]          perp_dist;
   } side_type;

   typedef struct packed {
      logic [REM_W-1:0]     rem;
      logic [NUM_W-1:0]     num;
      logic [NUM_W-1:0]     quo;
      logic [15:0]          den;
   } rdiv_type;

   typedef struct packed {
      logic [CH_N-1:0][15:0]     rem;
      logic [CH_N-1:0][CH_W-1:0] num;
      logic [CH_N-1:0][CH_W-1:0] quo;
      logic [CH_N-1:0][CH_W-1:0] chan;
      logic [15:0]               divisor;
      logic                      pass;
      logic                      zero;
   } cdiv_type;

endpackage

FILE: hdl/wtss_rdiv_cell.sv
module wtss_rdiv_cell #(
   parameter int BIT = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               up_valid,
   output logic               up_ready,
   input  wtss_pkg::side_type up_side,
   input  wtss_pkg::rdiv_type up_div,
   output logic               dn_valid,
   input  logic               dn_ready,
   output wtss_pkg::side_type dn_side,
   output wtss_pkg::rdiv_type dn_div
);
   import wtss_pkg::*;

   logic     valid_ff;
   side_type side_ff;
   rdiv_type div_ff;
   rdiv_type div_in;
   logic [REM_W:0] trial;
   logic     ready;

   assign ready    = !valid_ff || dn_ready;
   assign up_ready = ready;
   assign dn_valid = valid_ff;
   assign dn_side  = side_ff;
   assign dn_div   = div_ff;

   always_comb begin
      div_in = up_div;
      trial  = {up_div.rem, up_div.num[BIT]};
      if (trial >= {1'b0, up_div.den}) begin
         div_in.rem      = REM_W'(trial - {1'b0, up_div.den});
         div_in.quo[BIT] = 1'b1;
      end else begin
         div_in.rem = trial[REM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ready) begin
         side_ff <= up_side;
         div_ff  <= div_in;
      end
   end

endmodule

FILE: hdl/wtss_cdiv_cell.sv
module wtss_cdiv_cell #(
   parameter int BIT = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               up_valid,
   output logic               up_ready,
   input  wtss_pkg::cdiv_type up_div,
   output logic               dn_valid,
   input  logic               dn_ready,
   output wtss_pkg::cdiv_type dn_div
);
   import wtss_pkg::*;

   logic     valid_ff;
   cdiv_type div_ff;
   cdiv_type div_in;
   logic [CH_N-1:0][16:0] trial;
   logic     ready;

   assign ready    = !valid_ff || dn_ready;
   assign up_ready = ready;
   assign dn_valid = valid_ff;
   assign dn_div   = div_ff;

   always_comb begin
      div_in = up_div;
      for (int k = 0; k < CH_N; k++) begin
         trial[k] = {up_div.rem[k], up_div.num[k][BIT]};
         if (trial[k] >= {1'b0, up_div.divisor}) begin
            div_in.rem[k]      = 16'(trial[k] - {1'b0, up_div.divisor});
            div_in.quo[k][BIT] = 1'b1;
         end else begin
            div_in.rem[k] = trial[k][15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ready) begin
         div_ff <= div_in;
      end
   end

endmodule

FILE: hdl/wall_texel_sampler_with_distance_shade.sv
// Texture-mapped wall shader for a raycaster. Texel writes and shade requests share one
// stream and are handled in order. The pipeline takes one request per clock while results
// are accepted, and a shade result passes through one preparation stage, a row of 26 one-bit
// divider cells for the texture row, an address stage, the texture memory read, a
// multiply stage and a row of 8 one-bit divider cells for the distance shade. Stalls on
// the result side collapse bubbles, so requests keep flowing until the row is full. The
// texture memory is not cleared after reset; shade only texels that have been written.
module wall_texel_sampler_with_distance_shade #(
   parameter int TEX_W   = 64,
   parameter int TEX_H   = 64,
   parameter int NUM_TEX = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // texel_addr, texel_value, row, wall_x_frac, side, step_x_positive,
   // step_y_positive, line_height, walking_height, perp_dist, zero pad
   input  logic [111:0] req_tdata,
   // req_type
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // color
   output logic [23:0]  rsp_tdata,
   input  logic         csr_we,
   input  logic         csr_addr,
   input  logic [15:0]  csr_wdata
);
   import wtss_pkg::*;

   localparam int DEPTH = NUM_TEX * TEX_W * TEX_H;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [31:0] DEPTH_L = 32'(DEPTH);
   localparam logic csr_light  = 1'b0;
   localparam logic csr_height = 1'b1;

   logic [15:0] light_ff;
   logic [11:0] height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         light_ff  <= 16'd512;
         height_ff <= 12'd480;
      end else if (csr_we) begin
         unique case (csr_addr)
            csr_light:  light_ff  <= csr_wdata;
            csr_height: height_ff <= csr_wdata[11:0];
            default:    light_ff  <= light_ff;
         endcase
      end
   end

   // Request fields.
   logic [13:0] f_addr;
   logic [23:0] f_value;
   logic [10:0] f_row;
   logic [15:0] f_frac;
   logic        f_side, f_sxp, f_syp;
   logic [15:0] f_lh;
   logic [10:0] f_walk;
   logic [15:0] f_dist;

   assign f_addr  = req_tdata[13:0];
   assign f_value = req_tdata[37:14];
   assign f_row   = req_tdata[48:38];
   assign f_frac  = req_tdata[64:49];
   assign f_side  = req_tdata[65];
   assign f_sxp   = req_tdata[66];
   assign f_syp   = req_tdata[67];
   assign f_lh    = req_tdata[83:68];
   assign f_walk  = req_tdata[94:84];
   assign f_dist  = req_tdata[110:95];

   logic [26:0] col_prod;
   logic [COL_W-1:0] col_raw;
   logic [17:0] offset;
   logic [17:0] mag;
   logic [26:0] num_prod;
   side_type    s0_side_in;
   rdiv_type    s0_div_in;

   always_comb begin
      col_prod = 27'(f_frac) * 27'(TEX_W);
      col_raw  = col_prod[25:16];
      offset   = {7'b0, f_row} + {3'b0, f_lh[15:1]} - {7'b0, height_ff[11:1]}
               - {{7{f_walk[10]}}, f_walk};
      mag      = offset[17] ? 18'(-offset) : offset;
      num_prod = 27'(mag[15:0]) * 27'(TEX_H);

      s0_side_in.is_shade    = (req_tuser != 1'(TYPE_WRITE));
      s0_side_in.drop        = ({18'b0, f_addr} >= DEPTH_L);
      s0_side_in.neg         = offset[17];
      s0_side_in.texel_addr  = f_addr;
      s0_side_in.texel_value = f_value;
      s0_side_in.perp_dist   = f_dist;
      if (!f_side) begin
         s0_side_in.tex = f_sxp ? 2'd3 : 2'd2;
      end else begin
         s0_side_in.tex = f_syp ? 2'd0 : 2'd1;
      end
      if ((!f_side && !f_sxp) || (f_side && f_syp)) begin
         s0_side_in.col = COL_W'(TEX_W - 1) - col_raw;
      end else begin
         s0_side_in.col = col_raw;
      end

      s0_div_in.rem = '0;
      s0_div_in.num = num_prod[NUM_W-1:0];
      s0_div_in.quo = '0;
      s0_div_in.den = f_lh;
   end

   logic     rv [NUM_W+1];
   logic     rr [NUM_W+1];
   side_type rs [NUM_W+1];
   rdiv_type rd [NUM_W+1];

   logic     s0_valid_ff;
   side_type s0_side_ff;
   rdiv_type s0_div_ff;

   assign req_tready = !s0_valid_ff || rr[0];
   assign rv[0] = s0_valid_ff;
   assign rs[0] = s0_side_ff;
   assign rd[0] = s0_div_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s0_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         s0_side_ff <= s0_side_in;
         s0_div_ff  <= s0_div_in;
      end
   end

   for (genvar k = 0; k < NUM_W; k++) begin : g_row
      wtss_rdiv_cell #(.BIT(NUM_W - 1 - k)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (rv[k]),
         .up_ready (rr[k]),
         .up_side  (rs[k]),
         .up_div   (rd[k]),
         .dn_valid (rv[k+1]),
         .dn_ready (rr[k+1]),
         .dn_side  (rs[k+1]),
         .dn_div   (rd[k+1])
      );
   end

   // Address stage.
   logic          a_valid_ff, a_shade_ff, a_drop_ff;
   logic [AW-1:0] a_addr_ff;
   logic [23:0]   a_wdata_ff;
   logic [15:0]   a_dist_ff;
   logic          a_ready;
   logic          m_ready;
   logic [31:0]   a_addr_full;
   logic          a_black_in;
   side_type      e_side;
   logic [NUM_W-1:0] e_quo;

   assign e_side  = rs[NUM_W];
   assign e_quo   = rd[NUM_W].quo;
   assign a_ready = !a_valid_ff || m_ready;
   assign rr[NUM_W] = a_ready;

   always_comb begin
      a_black_in = (e_side.neg && (e_quo != '0)) || (e_quo > NUM_W'(TEX_H - 1));
      if (e_side.is_shade) begin
         a_addr_full = 32'(e_side.tex) * 32'(TEX_W * TEX_H)
                     + 32'(e_quo[COL_W-1:0]) * 32'(TEX_W) + 32'(e_side.col);
      end else begin
         a_addr_full = 32'(e_side.texel_addr);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= rv[NUM_W];
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready) begin
         a_shade_ff <= e_side.is_shade;
         a_drop_ff  <= e_side.is_shade ? a_black_in : e_side.drop;
         a_addr_ff  <= a_addr_full[AW-1:0];
         a_wdata_ff <= e_side.texel_value;
         a_dist_ff  <= e_side.perp_dist;
      end
   end

   // Texture memory stage.
   logic [23:0] mem [DEPTH];
   logic        m_valid_ff, m_black_ff;
   logic [23:0] m_data_ff;
   logic [15:0] m_dist_ff;
   logic        l_ready;

   assign m_ready = !m_valid_ff || l_ready;

   always_ff @(posedge clock) begin
      if (a_valid_ff && m_ready && !a_shade_ff && !a_drop_ff) begin
         mem[a_addr_ff] <= a_wdata_ff;
      end
      if (m_ready) begin
         m_data_ff <= mem[a_addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (m_ready) begin
         m_valid_ff <= a_valid_ff && a_shade_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (m_ready) begin
         m_black_ff <= a_drop_ff;
         m_dist_ff  <= a_dist_ff;
      end
   end

   // Multiply stage.
   logic     cv [9];
   logic     cr [9];
   cdiv_type cd [9];
   logic     l_valid_ff;
   cdiv_type l_div_ff;
   cdiv_type l_div_in;
   logic [CH_N-1:0][23:0] l_prod;

   assign l_ready = !l_valid_ff || cr[0];
   assign cv[0] = l_valid_ff;
   assign cd[0] = l_div_ff;

   always_comb begin
      for (int k = 0; k < CH_N; k++) begin
         l_div_in.chan[k] = m_data_ff[CH_W*k +: CH_W];
         l_prod[k]        = 24'(l_div_in.chan[k]) * 24'(light_ff);
         l_div_in.rem[k]  = l_prod[k][23:8];
         l_div_in.num[k]  = l_prod[k][7:0];
      end
      l_div_in.quo     = '0;
      l_div_in.divisor = m_dist_ff;
      l_div_in.pass = (m_dist_ff == 16'd0) ? (light_ff != 16'd0) : (light_ff >= m_dist_ff);
      l_div_in.zero = m_black_ff || ((m_dist_ff == 16'd0) && (light_ff == 16'd0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         l_valid_ff <= 1'b0;
      end else if (l_ready) begin
         l_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (l_ready) begin
         l_div_ff <= l_div_in;
      end
   end

   for (genvar j = 0; j < CH_W; j++) begin : g_shade
      wtss_cdiv_cell #(.BIT(CH_W - 1 - j)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (cv[j]),
         .up_ready (cr[j]),
         .up_div   (cd[j]),
         .dn_valid (cv[j+1]),
         .dn_ready (cr[j+1]),
         .dn_div   (cd[j+1])
      );
   end

   assign rsp_tvalid = cv[CH_W];
   assign cr[CH_W]   = rsp_tready;

   always_comb begin
      if (cd[CH_W].zero) begin
         rsp_tdata = 24'd0;
      end else if (cd[CH_W].pass) begin
         rsp_tdata = cd[CH_W].chan;
      end else begin
         rsp_tdata = cd[CH_W].quo;
      end
   end

endmodule

FILE: hdl/wtss_checker.sv
module wtss_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   // The pipeline is empty right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // Requests are refused only when the whole row is backed up from the result side.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("request refused without a result stall");

   // A waiting request with room ahead is taken in the same cycle.
   a_take: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && !rsp_tvalid) |-> req_tready)
      else $error("request refused while the result side is empty");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

endmodule

bind wall_texel_sampler_with_distance_shade wtss_checker u_wtss_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
